// ===== hw/rtl/reduced_idct_8x8_two_column_assert.svh =====
// Assertion macros for the reduced 8x8 IDCT block.
// Expects clk and arst_n in the scope of each use.
`ifndef REDUCED_IDCT_8X8_TWO_COLUMN_ASSERT_SVH
`define REDUCED_IDCT_8X8_TWO_COLUMN_ASSERT_SVH

// same-cycle implication
`define RIDCT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ridct assertion failed");

// next-cycle implication
`define RIDCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ridct assertion failed");

`endif

// ===== hw/rtl/ridct_pkg.sv =====
// Shared types, constants and the fixed-point multiply for the reduced 8x8 IDCT.
// No dependencies.
package ridct_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int COEF_SLOTS      = 16;
	localparam int CLIP_IDX_W      = 10;
	localparam int CLIP_LSB        = 5;

	localparam logic CMD_TABLE = 1'b0;
	localparam logic CMD_COEF  = 1'b1;

	localparam logic [1:0] ACT_ONE_COL = 2'd1;

	localparam logic [9:0] K_1_414 = 10'h16a;
	localparam logic [9:0] K_1_847 = 10'h1d9;
	localparam logic [9:0] K_2_613 = 10'h29d;
	localparam logic [9:0] K_1_082 = 10'h115;

	localparam logic [15:0] BIAS = 16'h1000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_COL,
		ST_ROWMUL,
		ST_CLIP,
		ST_EMIT
	} ridct_state_t;

	typedef enum logic [2:0] {
		CS_BUTTERFLY,
		CS_E3,
		CS_P,
		CS_Q,
		CS_R,
		CS_S,
		CS_OUT
	} col_step_t;

	typedef enum logic [1:0] {
		RS_P,
		RS_R,
		RS_S
	} row_step_t;

	typedef struct packed {
		logic      ld_en;
		logic [2:0] ld_idx;
		logic      step_en;
		col_step_t step;
	} col_ctrl_t;

	typedef struct packed {
		logic      step_en;
		row_step_t step;
		logic      one_col;
		logic [2:0] sel;
	} row_ctrl_t;

	// (v * k) mod 2^32, then arithmetic shift right by 8
	function automatic logic [31:0] mulc(input logic [31:0] v, input logic [9:0] k);
		logic [41:0] prod;
		prod = {10'd0, v} * {32'd0, k};
		return {{8{prod[31]}}, prod[31:8]};
	endfunction

endpackage

// ===== hw/rtl/ridct_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ridct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/ridct_col.sv =====
// 8-point AAN column transform, stepped with one shared constant multiplier.
// Depends on ridct_pkg.
module ridct_col (
	input  logic                clk,
	input  ridct_pkg::col_ctrl_t ctrl,
	input  logic [31:0]         ld_data,
	output logic [7:0][15:0]    res
);
	import ridct_pkg::*;

	logic [7:0][31:0] x_q;
	logic [31:0] d26_q, o0_q, o2_q, w_q, u_q;
	logic [15:0] e0_q, e1_q, e2_q, e3_q, sum_q, p_q, q_q, r_q, s_q;
	logic [31:0] o1, o3;
	logic [31:0] mul_v;
	logic [9:0]  mul_k;
	logic [15:0] m16;
	logic [15:0] ta, tb, tc, td;

	assign o1 = x_q[1] + x_q[7];
	assign o3 = x_q[3] + x_q[5];

	always_comb begin
		unique case (ctrl.step)
			CS_E3: begin
				mul_v = d26_q;
				mul_k = K_1_414;
			end
			CS_P: begin
				mul_v = w_q;
				mul_k = K_1_847;
			end
			CS_Q: begin
				mul_v = o2_q;
				mul_k = K_2_613;
			end
			CS_R: begin
				mul_v = u_q;
				mul_k = K_1_414;
			end
			CS_S: begin
				mul_v = o0_q;
				mul_k = K_1_082;
			end
			default: begin
				mul_v = '0;
				mul_k = '0;
			end
		endcase
	end

	assign m16 = 16'(mulc(mul_v, mul_k));

	always_ff @(posedge clk) begin
		if (ctrl.ld_en) begin
			x_q[ctrl.ld_idx] <= ld_data;
		end
		if (ctrl.step_en) begin
			unique case (ctrl.step)
				CS_BUTTERFLY: begin
					e0_q  <= 16'(x_q[0] + x_q[4]);
					e1_q  <= 16'(x_q[0] - x_q[4]);
					e2_q  <= 16'(x_q[2] + x_q[6]);
					d26_q <= x_q[2] - x_q[6];
					o0_q  <= x_q[1] - x_q[7];
					o2_q  <= x_q[5] - x_q[3];
					sum_q <= 16'(o3 + o1);
					w_q   <= (x_q[1] - x_q[7]) + (x_q[5] - x_q[3]);
					u_q   <= o1 - o3;
				end
				CS_E3: e3_q <= m16 - e2_q;
				CS_P:  p_q  <= m16;
				CS_Q:  q_q  <= p_q - m16 - sum_q;
				CS_R:  r_q  <= m16 - q_q;
				CS_S:  s_q  <= p_q - m16 - r_q;
				default: ;
			endcase
		end
	end

	assign ta = e0_q + e2_q;
	assign tb = e0_q - e2_q;
	assign tc = e3_q + e1_q;
	assign td = e1_q - e3_q;

	// valid during CS_OUT
	assign res[0] = ta + sum_q;
	assign res[1] = tc + q_q;
	assign res[2] = td + r_q;
	assign res[3] = tb + s_q;
	assign res[4] = tb - s_q;
	assign res[5] = td - r_q;
	assign res[6] = tc - q_q;
	assign res[7] = ta - sum_q;
endmodule

// ===== hw/rtl/ridct_row.sv =====
// Row pass: odd-part multiplies for one row (two-column mode only), then the clip index per sample.
// Depends on ridct_pkg.
module ridct_row (
	input  logic                              clk,
	input  ridct_pkg::row_ctrl_t               ctrl,
	input  logic [15:0]                       x0,
	input  logic [15:0]                       x1,
	output logic [ridct_pkg::CLIP_IDX_W-1:0]  clip_idx
);
	import ridct_pkg::*;

	logic [31:0] x1_ext;
	logic [9:0]  mul_k;
	logic [15:0] m16;
	logic [15:0] p_q, r_q, s_q;
	logic [15:0] q;
	logic [15:0] biased;
	logic [15:0] smp;

	assign x1_ext = {{16{x1[15]}}, x1};

	always_comb begin
		unique case (ctrl.step)
			RS_P:    mul_k = K_1_847;
			RS_R:    mul_k = K_1_414;
			RS_S:    mul_k = K_1_082;
			default: mul_k = '0;
		endcase
	end

	assign m16 = 16'(mulc(x1_ext, mul_k));
	assign q   = p_q - x1;

	always_ff @(posedge clk) begin
		if (ctrl.step_en) begin
			unique case (ctrl.step)
				RS_P:    p_q <= m16;
				RS_R:    r_q <= m16 - q;
				RS_S:    s_q <= p_q - m16 - r_q;
				default: ;
			endcase
		end
	end

	assign biased = x0 + BIAS;

	always_comb begin
		if (ctrl.one_col) begin
			smp = biased;
		end else begin
			unique case (ctrl.sel)
				3'd0: smp = biased + x1;
				3'd1: smp = biased + q;
				3'd2: smp = biased + r_q;
				3'd3: smp = biased + s_q;
				3'd4: smp = biased - s_q;
				3'd5: smp = biased - r_q;
				3'd6: smp = biased - q;
				3'd7: smp = biased - x1;
				default: smp = biased;
			endcase
		end
	end

	assign clip_idx = smp[CLIP_LSB +: CLIP_IDX_W];
endmodule

// ===== hw/rtl/reduced_idct_8x8_two_column.sv =====
// Top level of the reduced 8x8 IDCT: command port, coefficient store, clip table, sequencer.
// Depends on ridct_pkg, ridct_ram, ridct_col, ridct_row and the assertion macro header.
//
// A transaction is taken when start is high and busy is low. A clip table write or a
// coefficient element without last leaves busy low. The element marked last starts the
// transform: each column reads its eight coefficients through the store's single read port
// and runs 7 steps on the shared multiplier, then each row takes 3 multiply steps
// (two-column mode only), one clip table read per distinct sample plus a wait for the
// registered read data, and the row output. After last, busy stays high until row seven
// has been output. Each row appears on the result ports for exactly one cycle with strobe
// high and cannot be held off; rows come in order 0..7. The coefficient store is cleared at
// reset and after row seven, with no clearing pass. The clip table must be loaded before a
// block is run.
`include "reduced_idct_8x8_two_column_assert.svh"

module reduced_idct_8x8_two_column #(
	parameter int TABLE_DEPTH = ridct_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [9:0]  index,
	input  logic signed [15:0] coefficient,
	input  logic signed [15:0] quant_step,
	input  logic [7:0]  table_value,
	input  logic [1:0]  active_columns,
	input  logic        last,
	output logic        strobe,
	output logic [7:0]  sample0,
	output logic [7:0]  sample1,
	output logic [7:0]  sample2,
	output logic [7:0]  sample3,
	output logic [7:0]  sample4,
	output logic [7:0]  sample5,
	output logic [7:0]  sample6,
	output logic [7:0]  sample7,
	output logic [2:0]  row_number,
	output logic        last_row
);
	import ridct_pkg::*;

	localparam int TA_W = $clog2(TABLE_DEPTH);
	localparam int SA_W = $clog2(COEF_SLOTS);

	ridct_state_t state_q, state_d;
	col_step_t    cstep_q;
	row_step_t    rstep_q;
	logic [3:0]   cnt_q;
	logic         col_q;
	logic         one_col_q;
	logic [2:0]   row_q;
	logic         rd_vld_s1;
	logic [2:0]   rd_idx_s1;
	logic [COEF_SLOTS-1:0] valid_q;

	logic [7:0][15:0] c0_q, c1_q;
	logic [7:0][7:0]  samp_q;

	logic        accept;
	logic        store_we, clip_we;
	logic        store_re, clip_re;
	logic signed [31:0] product;
	logic [31:0] store_rdata;
	logic [7:0]  clip_rdata;
	logic [3:0]  clip_lim;
	logic [CLIP_IDX_W-1:0] clip_idx;
	logic [7:0][15:0] col_res;
	col_ctrl_t   col_ctrl;
	row_ctrl_t   row_ctrl;

	assign accept   = start && !busy;
	assign store_we = accept && cmd == CMD_COEF && index < 10'(COEF_SLOTS);
	assign clip_we  = accept && cmd == CMD_TABLE;
	assign product  = coefficient * quant_step;
	assign clip_lim = one_col_q ? 4'd1 : 4'd8;

	ridct_ram #(
		.WIDTH(32),
		.DEPTH(COEF_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(index[SA_W-1:0]),
		.wdata(product),
		.re   (store_re),
		.raddr({col_q, cnt_q[2:0]}),
		.rdata(store_rdata)
	);

	ridct_ram #(
		.WIDTH(8),
		.DEPTH(TABLE_DEPTH)
	) u_clip (
		.clk  (clk),
		.we   (clip_we),
		.waddr(index[TA_W-1:0]),
		.wdata(table_value),
		.re   (clip_re),
		.raddr(clip_idx[TA_W-1:0]),
		.rdata(clip_rdata)
	);

	ridct_col u_col (
		.clk    (clk),
		.ctrl   (col_ctrl),
		.ld_data(valid_q[{col_q, rd_idx_s1}] ? store_rdata : 32'd0),
		.res    (col_res)
	);

	ridct_row u_row (
		.clk     (clk),
		.ctrl    (row_ctrl),
		.x0      (c0_q[row_q]),
		.x1      (c1_q[row_q]),
		.clip_idx(clip_idx)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_COEF && last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (cnt_q == 4'd8) begin
					state_d = ST_COL;
				end
			end
			ST_COL: begin
				if (cstep_q == CS_OUT) begin
					if (!col_q && !one_col_q) begin
						state_d = ST_LOAD;
					end else if (one_col_q) begin
						state_d = ST_CLIP;
					end else begin
						state_d = ST_ROWMUL;
					end
				end
			end
			ST_ROWMUL: begin
				if (rstep_q == RS_S) begin
					state_d = ST_CLIP;
				end
			end
			ST_CLIP: begin
				if (cnt_q == clip_lim) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (row_q == 3'd7) begin
					state_d = ST_IDLE;
				end else if (one_col_q) begin
					state_d = ST_CLIP;
				end else begin
					state_d = ST_ROWMUL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy             = state_q != ST_IDLE;
		strobe           = state_q == ST_EMIT;
		store_re         = state_q == ST_LOAD && !cnt_q[3];
		clip_re          = state_q == ST_CLIP && cnt_q < clip_lim;
		col_ctrl.ld_en   = state_q == ST_LOAD && rd_vld_s1;
		col_ctrl.ld_idx  = rd_idx_s1;
		col_ctrl.step_en = state_q == ST_COL;
		col_ctrl.step    = cstep_q;
		row_ctrl.step_en = state_q == ST_ROWMUL;
		row_ctrl.step    = rstep_q;
		row_ctrl.one_col = one_col_q;
		row_ctrl.sel     = cnt_q[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cstep_q   <= CS_BUTTERFLY;
			rstep_q   <= RS_P;
			cnt_q     <= '0;
			col_q     <= 1'b0;
			one_col_q <= 1'b0;
			row_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			valid_q   <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= store_re || clip_re;
			rd_idx_s1 <= cnt_q[2:0];
			if (store_we) begin
				valid_q[index[SA_W-1:0]] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					col_q   <= 1'b0;
					row_q   <= '0;
					cstep_q <= CS_BUTTERFLY;
					rstep_q <= RS_P;
					if (accept) begin
						one_col_q <= active_columns == ACT_ONE_COL;
					end
				end
				ST_LOAD: begin
					cnt_q <= (cnt_q == 4'd8) ? 4'd0 : cnt_q + 4'd1;
				end
				ST_COL: begin
					unique case (cstep_q)
						CS_BUTTERFLY: cstep_q <= CS_E3;
						CS_E3:        cstep_q <= CS_P;
						CS_P:         cstep_q <= CS_Q;
						CS_Q:         cstep_q <= CS_R;
						CS_R:         cstep_q <= CS_S;
						CS_S:         cstep_q <= CS_OUT;
						default: begin
							cstep_q <= CS_BUTTERFLY;
							col_q   <= 1'b1;
						end
					endcase
				end
				ST_ROWMUL: begin
					unique case (rstep_q)
						RS_P:    rstep_q <= RS_R;
						RS_R:    rstep_q <= RS_S;
						default: rstep_q <= RS_P;
					endcase
				end
				ST_CLIP: begin
					cnt_q <= (cnt_q == clip_lim) ? 4'd0 : cnt_q + 4'd1;
				end
				ST_EMIT: begin
					row_q <= row_q + 3'd1;
					if (row_q == 3'd7) begin
						valid_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COL && cstep_q == CS_OUT) begin
			if (col_q) begin
				c1_q <= col_res;
			end else begin
				c0_q <= col_res;
			end
		end
		if (state_q == ST_CLIP && rd_vld_s1) begin
			if (one_col_q) begin
				samp_q <= {8{clip_rdata}};
			end else begin
				samp_q[rd_idx_s1] <= clip_rdata;
			end
		end
	end

	assign sample0    = samp_q[0];
	assign sample1    = samp_q[1];
	assign sample2    = samp_q[2];
	assign sample3    = samp_q[3];
	assign sample4    = samp_q[4];
	assign sample5    = samp_q[5];
	assign sample6    = samp_q[6];
	assign sample7    = samp_q[7];
	assign row_number = row_q;
	assign last_row   = row_q == 3'd7;

	`RIDCT_ASSERT_NEXT(a_last_starts, start && !busy && cmd == CMD_COEF && last, busy)
	`RIDCT_ASSERT_NEXT(a_block_ends, strobe && last_row, !busy && valid_q == '0)
	`RIDCT_ASSERT_NEXT(a_strobe_gap, strobe, !strobe)
	`RIDCT_ASSERT_NOW(a_no_load_write, store_re || clip_re, !store_we && !clip_we)
endmodule
